// ----- rtl/core/lpfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lpfs_pkg;

	localparam int LENGTH_BITS = 16;
	// Only the low header bits up to 16 take part in the length.
	localparam int LEN_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
	localparam int BYTES_W = 15;
	localparam logic [BYTES_W-1:0] MAX_LEN_RESET = 15'd2048;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] PH_LOW  = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_FAIL = 2'd3;

	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_ONE  = 2'd1;
	localparam logic [1:0] PUSH_TWO  = 2'd2;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_start;
		logic       frame_last;
		logic       length_error;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage
`default_nettype wire

// ----- rtl/core/lpfs_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpfs_parser
	import lpfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [BYTES_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         stream_byte,
	input  wire logic               space_ok,
	output push_t                   push
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic [BYTES_W-1:0] max_length_q;
	logic [1:0]         phase_q, phase_d;
	logic [7:0]         held_q, held_d;
	logic [BYTES_W-1:0] rem_q, rem_d, rem_dec;
	logic               adv;
	logic [15:0]        raw;
	logic [LEN_W-1:0]   len_raw;
	logic [15:0]        len_ext;
	logic               len_ok;

	assign adv      = valid_s1 && space_ok;
	assign in_stall = valid_s1 && !space_ok;

	assign raw     = {byte_s1, held_q};
	assign len_raw = raw[LEN_W-1:0];
	assign len_ext = 16'(len_raw);
	assign len_ok  = !len_raw[LEN_W-1] && (len_ext >= 16'd2)
		&& (len_ext <= {1'b0, max_length_q});
	assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

	always_comb begin
		push    = '0;
		phase_d = phase_q;
		held_d  = held_q;
		rem_d   = rem_q;
		if (adv) begin
			unique case (phase_q)
				PH_LOW: begin
					held_d  = byte_s1;
					phase_d = PH_HIGH;
				end
				PH_HIGH: begin
					if (!len_ok) begin
						// drop for good after a bad length
						push.n              = PUSH_ONE;
						push.r0.length_error = 1'b1;
						phase_d             = PH_FAIL;
						rem_d               = '0;
					end else begin
						push.n              = PUSH_TWO;
						push.r0.frame_byte  = held_q;
						push.r0.frame_start = 1'b1;
						push.r1.frame_byte  = byte_s1;
						push.r1.frame_last  = (len_ext == 16'd2);
						rem_d               = BYTES_W'(len_ext - 16'd2);
						phase_d             = (len_ext == 16'd2) ? PH_LOW : PH_BODY;
					end
				end
				PH_BODY: begin
					push.n             = PUSH_ONE;
					push.r0.frame_byte = byte_s1;
					push.r0.frame_last = (rem_dec == '0);
					rem_d              = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_LOW;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			max_length_q <= MAX_LEN_RESET;
			phase_q      <= PH_LOW;
			held_q       <= '0;
			rem_q        <= '0;
		end else begin
			if (cfg_we) begin
				max_length_q <= cfg_wdata;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			phase_q <= phase_d;
			held_q  <= held_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= stream_byte;
		end
	end

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAIL |=> phase_q == PH_FAIL)
		else $error("failed phase left without reset");

	a_error_from_header: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != PUSH_NONE && push.r0.length_error) |=> phase_q == PH_FAIL)
		else $error("length error without entering failed phase");

	a_two_only_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == PUSH_TWO |-> (phase_q == PH_HIGH && push.r0.frame_start))
		else $error("two-result request outside header high byte");

endmodule
`default_nettype wire

// ----- rtl/core/lpfs_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpfs_result_fifo
	import lpfs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       space_ok,
	output logic       out_valid,
	input  wire logic  out_stall,
	output result_t    head
);

	result_t            mem [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem[rd_q];
	// room for the two results of a header
	assign space_ok  = (count_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.n);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != PUSH_NONE) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == PUSH_TWO) begin
			mem[PTR_W'(wr_q + 1'b1)] <= push.r1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(push.n) <= CNT_W'(FIFO_DEPTH) - count_q)
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result count out of range");

	a_two_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == PUSH_TWO && !pop) |=> count_q == $past(count_q) + CNT_W'(2))
		else $error("two-result request not counted");

endmodule
`default_nettype wire

// ----- rtl/core/length_prefixed_frame_splitter_top.sv -----
// Length-prefixed frame splitter.
// Input channel: in_valid / in_stall with stream_byte, one stream byte per request.
// Output channel: out_valid / out_stall with frame_byte, frame_start, frame_last
// and length_error, one result per request.
// Each message opens with a 16-bit little-endian signed length that counts the
// whole message. The first header byte is held; on the second the length is
// checked against max_length (cfg_we / cfg_wdata, reset value 2048, write only
// while idle). A good header yields two results, the first flagged frame_start;
// body bytes yield one each, and the result of the message's last byte is flagged
// frame_last. A bad length yields a single length_error result and the block then
// drops all input until reset.
// Each accepted byte is registered in the parser's input stage; its results are
// written into the result queue once it has room, and are offered from there.
// Throughput: one byte per cycle; the output queue drains one result per cycle
// while out_stall is low, and the input stalls only while the four-entry result
// queue has fewer than two free slots.
// Reset clears the phase, the queue and sets max_length to 2048. A stalled
// receiver fills the queue and then backs up into in_stall; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module length_prefixed_frame_splitter_top
	import lpfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [BYTES_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         stream_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              frame_byte,
	output logic                    frame_start,
	output logic                    frame_last,
	output logic                    length_error
);

	push_t   push;
	logic    space_ok;
	result_t head;

	lpfs_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.stream_byte(stream_byte),
		.space_ok   (space_ok),
		.push       (push)
	);

	lpfs_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	assign frame_byte   = head.frame_byte;
	assign frame_start  = head.frame_start;
	assign frame_last   = head.frame_last;
	assign length_error = head.length_error;

endmodule
`default_nettype wire

// ----- tb/sv/length_prefixed_frame_splitter_top_tb.sv -----
`timescale 1ns / 1ps
module length_prefixed_frame_splitter_top_tb;
	import lpfs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned RANDOM_BYTES = 1600;
	localparam int unsigned DIR_ROWS = 23;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;
	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_e;
	typedef enum logic [1:0] {BAD_ZERO, BAD_ONE, BAD_NEGATIVE, BAD_OVER_MAX} bad_len_e;

	typedef struct {
		row_kind_e   kind;
		logic [14:0] data;
		bit          typed;
		int unsigned n;
		result_t     r0;
		result_t     r1;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [BYTES_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         stream_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         frame_byte;
	logic               frame_start;
	logic               frame_last;
	logic               length_error;

	length_prefixed_frame_splitter_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.frame_start (frame_start),
		.frame_last  (frame_last),
		.length_error(length_error)
	);

	// Deframer state as the testbench sees it
	logic [1:0]         split_phase = PH_LOW;
	logic [7:0]         split_held = '0;
	logic [14:0]        split_left = '0;
	logic [BYTES_W-1:0] split_max = MAX_LEN_RESET;

	result_t     due_results[$];
	result_t     got_due;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned messages = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned settings_count = 0;
	int unsigned input_stall_cycles = 0;
	int unsigned burst_left = 0;
	bit          sender_gaps = 1'b1;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{ROW_BYTE, 15'h02, 1'b1, 0, '0, '0},
		'{ROW_BYTE, 15'h00, 1'b1, 2, '{8'h02, 1'b1, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1, 1'b0}},
		'{ROW_BYTE, 15'h03, 1'b1, 0, '0, '0},
		'{ROW_BYTE, 15'h00, 1'b1, 2, '{8'h03, 1'b1, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE, 15'hFF, 1'b1, 1, '{8'hFF, 1'b0, 1'b1, 1'b0}, '0},
		'{ROW_BYTE, 15'h05, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h00, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h00, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h80, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h7F, 1'b0, 0, '0, '0},
		'{ROW_CFG,  15'd2,  1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h02, 1'b1, 0, '0, '0},
		'{ROW_BYTE, 15'h00, 1'b1, 2, '{8'h02, 1'b1, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1, 1'b0}},
		'{ROW_CFG,  15'h7FFF, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h04, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h00, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h5A, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'hA5, 1'b0, 0, '0, '0},
		'{ROW_CFG,  15'd3,  1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h03, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h00, 1'b0, 0, '0, '0},
		'{ROW_BYTE, 15'h01, 1'b0, 0, '0, '0},
		'{ROW_CFG,  15'd2048, 1'b0, 0, '0, '0}
	};

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (in_valid && in_stall)
			input_stall_cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic split_byte(input logic [7:0] b, output int unsigned n,
			output result_t r0, output result_t r1);
		logic [15:0] raw;
		int          len;
		n = 0;
		r0 = '0;
		r1 = '0;
		case (split_phase)
			PH_LOW: begin
				split_held = b;
				split_phase = PH_HIGH;
			end
			PH_HIGH: begin
				raw = {b, split_held};
				// sign bit of the length field makes it invalid
				if (raw[LEN_W-1])
					len = -1;
				else
					len = int'(raw) & ((1 << LEN_W) - 1);
				if (len < 2 || len > int'(split_max)) begin
					n = 1;
					r0 = '{8'h00, 1'b0, 1'b0, 1'b1};
					split_left = '0;
					split_phase = PH_FAIL;
				end else begin
					n = 2;
					r0 = '{split_held, 1'b1, 1'b0, 1'b0};
					r1 = '{b, 1'b0, (len == 2), 1'b0};
					split_left = 15'(len - 2);
					split_phase = (split_left == 0) ? PH_LOW : PH_BODY;
				end
			end
			PH_BODY: begin
				if (split_left != 0)
					split_left = split_left - 15'd1;
				n = 1;
				r0 = '{b, 1'b0, (split_left == 0), 1'b0};
				if (split_left == 0)
					split_phase = PH_LOW;
			end
			default: ;
		endcase
	endtask

	// Offer one byte in the sender's burst pattern and record what it must produce
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input int unsigned typed_n = 0, input result_t t0 = '0, input result_t t1 = '0);
		int unsigned gap;
		int unsigned n;
		result_t     p0;
		result_t     p1;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if (sender_gaps) begin
				gap = $urandom_range(1, 6);
				repeat (gap) @(negedge clk) in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		split_byte(b, n, p0, p1);
		if (typed) begin
			n = typed_n;
			p0 = t0;
			p1 = t1;
		end
		if (n > 0)
			due_results.push_back(p0);
		if (n > 1)
			due_results.push_back(p1);
	endtask

	task automatic send_message(input int unsigned len);
		int unsigned i;
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (i = 2; i < len; i++)
			send_byte(8'($urandom));
		messages++;
	endtask

	task automatic wait_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [BYTES_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		split_max = v;
		settings_count++;
	endtask

	function automatic int unsigned pick_length(input int unsigned lim);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(2, (lim < 24) ? lim : 24);
		if (roll < 90)
			return $urandom_range(2, (lim < 400) ? lim : 400);
		// hit the configured limit exactly when it is cheap to do so
		return (lim <= 400) ? lim : $urandom_range(256, 400);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_results.size() == 0) begin
				$error("unexpected result: frame_byte %02h start %0b last %0b error %0b",
					frame_byte, frame_start, frame_last, length_error);
				fail_count++;
			end else begin
				got_due = due_results.pop_front();
				if (frame_byte !== got_due.frame_byte) begin
					$error("frame_byte: expected %02h, got %02h", got_due.frame_byte, frame_byte);
					fail_count++;
				end
				if (frame_start !== got_due.frame_start) begin
					$error("frame_start: expected %0b, got %0b", got_due.frame_start, frame_start);
					fail_count++;
				end
				if (frame_last !== got_due.frame_last) begin
					$error("frame_last: expected %0b, got %0b", got_due.frame_last, frame_last);
					fail_count++;
				end
				if (length_error !== got_due.length_error) begin
					$error("length_error: expected %0b, got %0b", got_due.length_error,
						length_error);
					fail_count++;
				end
			end
		end
	end

	initial begin : receiver
		rx_mode_e    mode;
		int unsigned left;
		bit          held_once;
		mode = RX_FREE;
		left = 0;
		held_once = 1'b0;
		forever begin
			// hold off long enough for the result queue to back up into in_stall
			if (!held_once && results_seen >= 300) begin
				held_once = 1'b1;
				repeat (300) @(negedge clk) out_stall <= 1'b1;
			end
			if (left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				left = $urandom_range(40, 300);
			end
			left--;
			@(negedge clk);
			case (mode)
				RX_FREE:   out_stall <= 1'b0;
				RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
				default:   out_stall <= ((left % 5) < 3);
			endcase
		end
	end

	initial begin : stimulus
		int unsigned      k;
		int unsigned      msg_count;
		int unsigned      lim;
		int unsigned      bad_len;
		int unsigned      dropped;
		bad_len_e         bad_kind;
		logic [7:0]       bad_low;
		logic [7:0]       bad_high;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (k = 0; k < DIR_ROWS; k++) begin
			if (dir_rows[k].kind == ROW_CFG)
				write_max_length(dir_rows[k].data);
			else
				send_byte(dir_rows[k].data[7:0], dir_rows[k].typed, dir_rows[k].n,
					dir_rows[k].r0, dir_rows[k].r1);
		end

		while (bytes_sent < RANDOM_BYTES) begin
			case ($urandom_range(0, 4))
				0:       lim = 2;
				1:       lim = $urandom_range(3, 40);
				2:       lim = $urandom_range(41, 32767);
				3:       lim = 32767;
				default: lim = MAX_LEN_RESET;
			endcase
			write_max_length(15'(lim));
			sender_gaps = ($urandom_range(0, 3) != 0);
			msg_count = $urandom_range(4, 30);
			for (k = 0; k < msg_count && bytes_sent < RANDOM_BYTES; k++)
				send_message(pick_length(lim));
		end

		// a bad length latches the failure for the rest of the run
		lim = $urandom_range(2, 32766);
		write_max_length(15'(lim));
		sender_gaps = 1'b1;
		msg_count = $urandom_range(0, 3);
		for (k = 0; k < msg_count; k++)
			send_message(pick_length(lim));
		bad_kind = bad_len_e'($urandom_range(0, 3));
		case (bad_kind)
			BAD_ZERO:     bad_len = 0;
			BAD_ONE:      bad_len = 1;
			BAD_NEGATIVE: bad_len = ($urandom_range(128, 255) << 8) | $urandom_range(0, 255);
			default:      bad_len = lim + 1;
		endcase
		bad_low = bad_len[7:0];
		bad_high = bad_len[15:8];
		send_byte(bad_low);
		send_byte(bad_high, 1'b1, 1, '{8'h00, 1'b0, 1'b0, 1'b1}, '0);
		dropped = $urandom_range(16, 40);
		for (k = 0; k < dropped; k++)
			send_byte(8'($urandom));

		wait_idle();
		repeat (16) @(posedge clk);
		$display("Sent %0d stream bytes in %0d messages under %0d max_length settings",
			bytes_sent, messages, settings_count);
		$display("Checked %0d results; input held off %0d cycles; closed on bad length %s",
			results_seen, input_stall_cycles, bad_kind.name());
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- length_prefixed_frame_splitter_top.f -----
rtl/core/lpfs_pkg.sv
rtl/core/lpfs_parser.sv
rtl/core/lpfs_result_fifo.sv
rtl/core/length_prefixed_frame_splitter_top.sv
tb/sv/length_prefixed_frame_splitter_top_tb.sv
